[design/aekd_pkg.sv]
// Package: payload structs, key codes, sequence states and byte constants.
`default_nettype none
package aekd_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] key_code;
        logic [7:0] char_value;
    } t_out_item;

    typedef enum logic [3:0] {
        K_NONE      = 4'd0,
        K_CHAR      = 4'd1,
        K_ENTER     = 4'd2,
        K_BACKSPACE = 4'd3,
        K_TAB       = 4'd4,
        K_UP        = 4'd5,
        K_DOWN      = 4'd6,
        K_RIGHT     = 4'd7,
        K_LEFT      = 4'd8,
        K_HOME      = 4'd9,
        K_END       = 4'd10,
        K_DELETE    = 4'd11,
        K_EOF       = 4'd12
    } t_key;

    typedef enum logic [2:0] {
        SEQ_IDLE   = 3'd0,
        SEQ_ESC    = 3'd1,
        SEQ_ESC_O  = 3'd2,
        SEQ_ESC_BR = 3'd3,
        SEQ_DIGIT  = 3'd4
    } t_seq;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_HIGH  = 8'h80;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_SS3   = 8'h4F;
    localparam logic [7:0] BYTE_CSI   = 8'h5B;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    typedef struct packed {
        logic      emit;
        t_out_item item;
    } t_step;

endpackage
`default_nettype wire

[design/aekd_fsm.sv]
// Sequence state machine: state registers and per-item next state and result.
`default_nettype none
module aekd_fsm (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire aekd_pkg::t_in_item i_item,
    output aekd_pkg::t_step        o_step
);
    import aekd_pkg::*;

    t_seq       r_state, n_state;
    logic [3:0] r_digit, n_digit;
    logic [7:0] b;

    assign b = i_item.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_digit <= 4'd0;
        end else if (i_advance) begin
            r_state <= n_state;
            r_digit <= n_digit;
        end
    end

    // next state
    always_comb begin
        n_state = SEQ_IDLE;
        n_digit = 4'd0;
        if (!i_item.mode) begin
            unique case (r_state)
                SEQ_IDLE:   if (b == BYTE_ESC) n_state = SEQ_ESC;
                SEQ_ESC: begin
                    if (b == BYTE_SS3) n_state = SEQ_ESC_O;
                    else if (b == BYTE_CSI) n_state = SEQ_ESC_BR;
                end
                SEQ_ESC_O:  n_state = SEQ_IDLE;
                SEQ_ESC_BR: begin
                    if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
                        n_state = SEQ_DIGIT;
                        n_digit = b[3:0];
                    end
                end
                SEQ_DIGIT:  n_state = SEQ_IDLE;
                default:    if (b == BYTE_ESC) n_state = SEQ_ESC;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_step.emit            = 1'b1;
        o_step.item.key_code   = K_NONE;
        o_step.item.char_value = 8'd0;
        unique case (r_state)
            SEQ_ESC: begin
                if (!i_item.mode && (b == BYTE_SS3 || b == BYTE_CSI)) o_step.emit = 1'b0;
            end
            SEQ_ESC_O: begin
                if (!i_item.mode) begin
                    if (b == "H") o_step.item.key_code = K_HOME;
                    else if (b == "F") o_step.item.key_code = K_END;
                end
            end
            SEQ_ESC_BR: begin
                if (!i_item.mode) begin
                    case (b)
                        "A": o_step.item.key_code = K_UP;
                        "B": o_step.item.key_code = K_DOWN;
                        "C": o_step.item.key_code = K_RIGHT;
                        "D": o_step.item.key_code = K_LEFT;
                        "H": o_step.item.key_code = K_HOME;
                        "F": o_step.item.key_code = K_END;
                        default: if (b >= BYTE_ZERO && b <= BYTE_NINE) o_step.emit = 1'b0;
                    endcase
                end
            end
            SEQ_DIGIT: begin
                if (!i_item.mode && b == BYTE_TILDE) begin
                    case (r_digit)
                        4'd1, 4'd7: o_step.item.key_code = K_HOME;
                        4'd4, 4'd8: o_step.item.key_code = K_END;
                        4'd3:       o_step.item.key_code = K_DELETE;
                        default:    o_step.item.key_code = K_NONE;
                    endcase
                end
            end
            default: begin
                if (i_item.mode) o_step.item.key_code = K_EOF;
                else if (b == BYTE_ESC) o_step.emit = 1'b0;
                else if (b == BYTE_DEL || b == BYTE_BS) o_step.item.key_code = K_BACKSPACE;
                else if (b == BYTE_TAB) o_step.item.key_code = K_TAB;
                else if (b == BYTE_LF || b == BYTE_CR) o_step.item.key_code = K_ENTER;
                else if ((b >= BYTE_SPACE && b < BYTE_DEL) || b >= BYTE_HIGH) begin
                    o_step.item.key_code   = K_CHAR;
                    o_step.item.char_value = b;
                end
            end
        endcase
    end
endmodule
`default_nettype wire

[design/aekd_out_reg.sv]
// Output register with skid stage for the result channel.
`default_nettype none
module aekd_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire aekd_pkg::t_out_item i_item,
    output logic                     o_ready,
    output logic                     o_valid,
    output aekd_pkg::t_out_item      o_item,
    input  wire logic                i_stall
);
    import aekd_pkg::*;

    logic      r_valid, r_skid_valid;
    t_out_item r_item, r_skid_item;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) begin
                r_valid      <= r_skid_valid || i_valid;
                r_skid_valid <= 1'b0;
            end else if (i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || !i_stall) begin
            r_item <= r_skid_valid ? r_skid_item : i_item;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_item <= i_item;
        end
    end
endmodule
`default_nettype wire

[design/ansi_escape_key_decoder_top.sv]
// Top level: ANSI escape sequence key decoder.
// Result path: the state update and key classification sit in one combinational stage
// in front of the output register; during output stall a result waits in the skid stage.
// Throughput: one byte per cycle while o_stall is low; the skid stage takes one byte during output stall.
// Reset: synchronous active low; sequence state to idle, held digit to zero, no result pending.
`default_nettype none
module ansi_escape_key_decoder_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire aekd_pkg::t_in_item  i_item,
    output logic                     o_stall,
    output logic                     o_valid,
    output aekd_pkg::t_out_item      o_item,
    input  wire logic                i_stall
);
    import aekd_pkg::*;

    logic  ready;
    logic  advance;
    t_step step;

    assign o_stall = !ready;
    assign advance = i_valid && ready;

    aekd_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (i_item),
        .o_step    (step)
    );

    aekd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance && step.emit),
        .i_item  (step.item),
        .o_ready (ready),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );
endmodule
`default_nettype wire

[design/aekd_checker.sv]
// Port-level checker for the key decoder, bound to the top level.
`default_nettype none
module aekd_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire aekd_pkg::t_in_item  i_item,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire aekd_pkg::t_out_item o_item,
    input wire logic                i_stall
);
    import aekd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.key_code != K_CHAR |-> o_item.char_value == 8'd0)
        else $error("char_value set on non-char key");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.key_code <= K_EOF)
        else $error("key_code out of range");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    a_idle_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && i_valid && !o_stall && i_item.mode
        |=> o_valid && o_item.key_code == K_EOF)
        else $error("end event after reset did not give eof");
endmodule

bind ansi_escape_key_decoder_top aekd_checker u_aekd_checker (.*);
`default_nettype wire
